// File: sv/tobj_pkg.sv
// Package for the tagged object ALU: word layout constants, operation and
// status codes, pipeline stage types and the per-stage helper functions.
// No dependencies.
package tobj_pkg;

  localparam int WORD_W    = 15;
  localparam int NUM_BIAS  = 8092;
  localparam int NUM_MAX   = 24000;
  localparam int ATOM_END  = 256;
  localparam int LIST_LAST = 6998;
  localparam int SUM_W     = WORD_W + 2;
  localparam int PROD_W    = 2 * WORD_W;
  // one pipeline stage for the operand setup plus one per quotient bit
  localparam int NSTG      = WORD_W + 1;

  typedef logic [WORD_W-1:0] word_t;

  localparam word_t OBJ_NIL = word_t'(0);
  localparam word_t OBJ_T   = word_t'(2);

  typedef enum logic [3:0] {
    OP_ADD1, OP_SUB1, OP_NULL, OP_NUMBERP, OP_ATOM, OP_LISTP, OP_EQ, OP_PLUS,
    OP_DIFF, OP_TIMES, OP_QUOT, OP_REM, OP_LT, OP_GT, OP_LE, OP_GE
  } op_t;

  typedef enum logic [1:0] {
    ST_OK, ST_TYPE, ST_DIVZERO, ST_RANGE
  } status_t;

  // after decode: operands unbiased, early answers resolved
  typedef struct packed {
    op_t     op;
    logic    done;
    word_t   obj;
    status_t st;
    word_t   a;
    word_t   b;
  } dec_t;

  // arithmetic stage and divider steps
  typedef struct packed {
    op_t              op;
    logic             done;
    word_t            obj;
    status_t          st;
    logic [SUM_W-1:0] sum;
    logic [PROD_W-1:0] prod;
    logic             cmp;
    word_t            rem;
    word_t            quo;
    word_t            dend;
    word_t            dvs;
  } stage_t;

  typedef struct packed {
    word_t   obj;
    status_t st;
  } result_t;

  function automatic logic is_number(word_t w);
    return (w >= word_t'(NUM_BIAS)) && (w <= word_t'(NUM_BIAS + NUM_MAX));
  endfunction

  function automatic logic is_atom(word_t w);
    return w < word_t'(ATOM_END);
  endfunction

  function automatic logic is_list(word_t w);
    return (w >= word_t'(ATOM_END)) && (w <= word_t'(LIST_LAST + 1));
  endfunction

  function automatic word_t truth(logic b);
    return b ? OBJ_T : OBJ_NIL;
  endfunction

  // one restoring division step, dividend MSB shifted into the partial remainder
  function automatic stage_t div_step(stage_t s);
    stage_t        r;
    logic [WORD_W:0] trial;
    logic          take;
    r     = s;
    trial = {s.rem, s.dend[WORD_W-1]};
    take  = trial >= {1'b0, s.dvs};
    if (take) begin
      r.rem = word_t'(trial - {1'b0, s.dvs});
    end else begin
      r.rem = trial[WORD_W-1:0];
    end
    r.dend = {s.dend[WORD_W-2:0], 1'b0};
    r.quo  = {s.quo[WORD_W-2:0], take};
    return r;
  endfunction

endpackage

// File: sv/tagged_object_alu.sv
// Tagged object ALU top level: decode, arithmetic, pipelined restoring
// divider and output register. Depends on tobj_pkg.
//
//   channel | ports                         | payload
//   --------+-------------------------------+------------------------------------
//   input   | in_tvalid in_tready in_tdata  | operation, first_object, second_obj
//   result  | out_tvalid out_tready out_tdata | result_object, status
//
// One transaction in per cycle while no stage is blocked, one result out per
// transaction. Stages: decode, arithmetic, 15 divider steps (one quotient bit each), output.
// The divider's bit-per-stage chain sets the depth. rst_n clears the valid bits
// only. Each stage holds while the one after it is full and blocked; empty
// stages fill in, so the input keeps taking transactions while a result waits.
module tagged_object_alu (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [3:0] operation, [18:4] first_object,
                                  // [33:19] second_object, [39:34] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // [14:0] result_object, [16:15] status,
                                  // [23:17] zero
);
  import tobj_pkg::*;

  dec_t    dec_r, dec_nxt;
  logic    dec_vld_r;
  logic    dec_en;

  stage_t  stg_r [NSTG];
  stage_t  stg0_nxt;
  logic    [NSTG-1:0] stg_vld_r;
  logic    [NSTG-1:0] stg_en;

  result_t out_r, out_nxt;
  logic    out_vld_r;
  logic    out_en;

  // ready chain: a stage may load when empty or when its successor moves
  always_comb begin
    out_en           = !out_vld_r || out_tready;
    stg_en[NSTG-1]   = !stg_vld_r[NSTG-1] || out_en;
    for (int k = NSTG - 2; k >= 0; k--) begin
      stg_en[k] = !stg_vld_r[k] || stg_en[k+1];
    end
    dec_en = !dec_vld_r || stg_en[0];
  end

  assign in_tready = dec_en;

  // decode
  always_comb begin
    op_t   op;
    word_t x;
    word_t y;
    op  = op_t'(in_tdata[3:0]);
    x   = in_tdata[4 +: WORD_W];
    y   = in_tdata[4 + WORD_W +: WORD_W];
    dec_nxt.op   = op;
    dec_nxt.a    = x - word_t'(NUM_BIAS);
    dec_nxt.b    = y - word_t'(NUM_BIAS);
    dec_nxt.done = 1'b1;
    dec_nxt.obj  = OBJ_NIL;
    dec_nxt.st   = ST_OK;
    case (op)
      OP_NULL:    dec_nxt.obj = truth(x == OBJ_NIL);
      OP_NUMBERP: dec_nxt.obj = truth(is_number(x));
      OP_ATOM:    dec_nxt.obj = truth(is_atom(x) || is_number(x));
      OP_LISTP:   dec_nxt.obj = truth(is_list(x));
      OP_EQ:      dec_nxt.obj = truth(x == y);
      OP_ADD1, OP_SUB1: begin
        if (!is_number(x)) begin
          dec_nxt.st = ST_TYPE;
        end else begin
          dec_nxt.done = 1'b0;
        end
      end
      default: begin
        if (!is_number(x) || !is_number(y)) begin
          dec_nxt.st = ST_TYPE;
        end else if ((op == OP_QUOT || op == OP_REM) && y == word_t'(NUM_BIAS)) begin
          dec_nxt.st = ST_DIVZERO;
        end else begin
          dec_nxt.done = 1'b0;
        end
      end
    endcase
  end

  // arithmetic and divider setup
  always_comb begin
    logic [SUM_W-1:0] ea;
    logic [SUM_W-1:0] eb;
    ea = {2'b00, dec_r.a};
    eb = {2'b00, dec_r.b};
    stg0_nxt.op   = dec_r.op;
    stg0_nxt.done = dec_r.done;
    stg0_nxt.obj  = dec_r.obj;
    stg0_nxt.st   = dec_r.st;
    stg0_nxt.prod = {{WORD_W{1'b0}}, dec_r.a} * {{WORD_W{1'b0}}, dec_r.b};
    stg0_nxt.rem  = '0;
    stg0_nxt.quo  = '0;
    stg0_nxt.dend = dec_r.a;
    stg0_nxt.dvs  = dec_r.b;
    case (dec_r.op)
      OP_ADD1: stg0_nxt.sum = ea + SUM_W'(1);
      OP_SUB1: stg0_nxt.sum = ea - SUM_W'(1);
      OP_PLUS: stg0_nxt.sum = ea + eb;
      default: stg0_nxt.sum = ea - eb;
    endcase
    case (dec_r.op)
      OP_LT:   stg0_nxt.cmp = dec_r.a <  dec_r.b;
      OP_GT:   stg0_nxt.cmp = dec_r.a >  dec_r.b;
      OP_LE:   stg0_nxt.cmp = dec_r.a <= dec_r.b;
      default: stg0_nxt.cmp = dec_r.a >= dec_r.b;
    endcase
  end

  // final selection and range check
  always_comb begin
    stage_t s;
    word_t  val;
    logic   oor;
    s   = stg_r[NSTG-1];
    val = '0;
    oor = 1'b0;
    out_nxt.obj = OBJ_NIL;
    out_nxt.st  = ST_OK;
    case (s.op)
      OP_ADD1, OP_SUB1, OP_PLUS, OP_DIFF: begin
        oor = s.sum[SUM_W-1] || (s.sum > SUM_W'(NUM_MAX));
        val = s.sum[WORD_W-1:0];
      end
      OP_TIMES: begin
        oor = s.prod > PROD_W'(NUM_MAX);
        val = s.prod[WORD_W-1:0];
      end
      OP_QUOT: val = s.quo;
      OP_REM:  val = s.rem;
      default: val = '0;
    endcase
    if (s.done) begin
      out_nxt.obj = s.obj;
      out_nxt.st  = s.st;
    end else if (s.op == OP_LT || s.op == OP_GT || s.op == OP_LE || s.op == OP_GE) begin
      out_nxt.obj = truth(s.cmp);
    end else if (oor) begin
      out_nxt.st  = ST_RANGE;
    end else begin
      out_nxt.obj = val + word_t'(NUM_BIAS);
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dec_vld_r <= 1'b0;
      stg_vld_r <= '0;
      out_vld_r <= 1'b0;
    end else begin
      if (dec_en) begin
        dec_vld_r <= in_tvalid;
      end
      if (stg_en[0]) begin
        stg_vld_r[0] <= dec_vld_r;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (stg_en[k]) begin
          stg_vld_r[k] <= stg_vld_r[k-1];
        end
      end
      if (out_en) begin
        out_vld_r <= stg_vld_r[NSTG-1];
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (dec_en) begin
      dec_r <= dec_nxt;
    end
    if (stg_en[0]) begin
      stg_r[0] <= stg0_nxt;
    end
    for (int k = 1; k < NSTG; k++) begin
      if (stg_en[k]) begin
        stg_r[k] <= div_step(stg_r[k-1]);
      end
    end
    if (out_en) begin
      out_r <= out_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {7'b0, out_r.st, out_r.obj};

endmodule

// File: dv/tb_tagged_object_alu.sv
// Self-checking testbench for tagged_object_alu: directed table, then random
// stream transactions with idle gaps and output stalls, all scored in order.
// Depends on tobj_pkg and tagged_object_alu.
`timescale 1ns / 1ps

module tb_tagged_object_alu;
  import tobj_pkg::*;

  localparam int N_DIRECTED = 25;
  localparam int N_RANDOM   = 450;
  localparam int DRAIN_WAIT = 40;   // idle clocks after the last result is scored

  typedef struct packed {
    op_t     op;
    word_t   x;
    word_t   y;
    logic    typed;   // expected answer given in the row, else predicted
    word_t   obj;
    status_t st;
  } alu_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;  // [3:0] operation, [18:4] first_object,
                               // [33:19] second_object, [39:34] zero
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;      // [14:0] result_object, [16:15] status,
                               // [23:17] zero

  result_t pending_results[$];
  result_t oldest_result;
  int      fail_count = 0;
  bit      calm = 1'b0;        // no gaps on either side while set

  alu_row_t alu_rows [N_DIRECTED] = '{
    '{OP_ADD1,    15'd8092,  15'd0,     1'b1, 15'd8093, ST_OK},
    '{OP_ADD1,    15'd32092, 15'd0,     1'b1, OBJ_NIL,  ST_RANGE},
    '{OP_SUB1,    15'd8092,  15'd0,     1'b1, OBJ_NIL,  ST_RANGE},
    '{OP_SUB1,    15'd32767, 15'd32767, 1'b1, OBJ_NIL,  ST_TYPE},
    '{OP_NULL,    15'd0,     15'd32767, 1'b1, OBJ_T,    ST_OK},
    '{OP_NUMBERP, 15'd8091,  15'd0,     1'b1, OBJ_NIL,  ST_OK},
    '{OP_NUMBERP, 15'd32092, 15'd0,     1'b1, OBJ_T,    ST_OK},
    '{OP_ATOM,    15'd255,   15'd0,     1'b1, OBJ_T,    ST_OK},
    '{OP_ATOM,    15'd256,   15'd0,     1'b1, OBJ_NIL,  ST_OK},
    '{OP_ATOM,    15'd8092,  15'd0,     1'b1, OBJ_T,    ST_OK},
    '{OP_LISTP,   15'd6999,  15'd0,     1'b1, OBJ_T,    ST_OK},
    '{OP_EQ,      15'd32767, 15'd32767, 1'b1, OBJ_T,    ST_OK},
    '{OP_PLUS,    15'd32092, 15'd8093,  1'b1, OBJ_NIL,  ST_RANGE},
    '{OP_DIFF,    15'd8092,  15'd8093,  1'b1, OBJ_NIL,  ST_RANGE},
    '{OP_TIMES,   15'd32092, 15'd32092, 1'b1, OBJ_NIL,  ST_RANGE},
    '{OP_QUOT,    15'd20000, 15'd8092,  1'b1, OBJ_NIL,  ST_DIVZERO},
    '{OP_REM,     15'd8092,  15'd8092,  1'b1, OBJ_NIL,  ST_DIVZERO},
    '{OP_PLUS,    15'd8092,  15'd7999,  1'b1, OBJ_NIL,  ST_TYPE},
    '{OP_QUOT,    15'd32092, 15'd8095,  1'b0, OBJ_NIL,  ST_OK},
    '{OP_REM,     15'd32092, 15'd8099,  1'b0, OBJ_NIL,  ST_OK},
    '{OP_LT,      15'd9000,  15'd9000,  1'b0, OBJ_NIL,  ST_OK},
    '{OP_GT,      15'd32092, 15'd8092,  1'b0, OBJ_NIL,  ST_OK},
    '{OP_GE,      15'd8092,  15'd32092, 1'b0, OBJ_NIL,  ST_OK},
    '{OP_TIMES,   15'd8100,  15'd8102,  1'b0, OBJ_NIL,  ST_OK},
    '{OP_LT,      15'd0,     15'd8092,  1'b1, OBJ_NIL,  ST_TYPE}
  };

  tagged_object_alu dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Expected answer for one operation on two tagged words.
  function automatic result_t lisp_alu_answer(op_t op, word_t x, word_t y);
    result_t r;
    int      a;
    int      b;
    int      v;
    logic    x_num;
    logic    y_num;
    logic    is_value;
    a        = int'(x) - NUM_BIAS;
    b        = int'(y) - NUM_BIAS;
    v        = 0;
    x_num    = (a >= 0) && (a <= NUM_MAX);
    y_num    = (b >= 0) && (b <= NUM_MAX);
    is_value = 1'b0;
    r.obj    = OBJ_NIL;
    r.st     = ST_OK;
    case (op)
      OP_NULL:    r.obj = (x == OBJ_NIL) ? OBJ_T : OBJ_NIL;
      OP_NUMBERP: r.obj = x_num ? OBJ_T : OBJ_NIL;
      OP_ATOM:    r.obj = (int'(x) < ATOM_END || x_num) ? OBJ_T : OBJ_NIL;
      OP_LISTP: begin
        r.obj = (int'(x) >= ATOM_END && int'(x) <= LIST_LAST + 1) ? OBJ_T : OBJ_NIL;
      end
      OP_EQ:      r.obj = (x == y) ? OBJ_T : OBJ_NIL;
      default: begin
        // type check wins over every other check
        if (!x_num || (op > OP_EQ && !y_num)) begin
          r.st = ST_TYPE;
        end else begin
          case (op)
            OP_ADD1:  begin v = a + 1; is_value = 1'b1; end
            OP_SUB1:  begin v = a - 1; is_value = 1'b1; end
            OP_PLUS:  begin v = a + b; is_value = 1'b1; end
            OP_DIFF:  begin v = a - b; is_value = 1'b1; end
            OP_TIMES: begin v = a * b; is_value = 1'b1; end
            OP_QUOT, OP_REM: begin
              if (b == 0) begin
                r.st = ST_DIVZERO;
              end else begin
                v        = (op == OP_QUOT) ? a / b : a % b;
                is_value = 1'b1;
              end
            end
            OP_LT:    r.obj = (a < b) ? OBJ_T : OBJ_NIL;
            OP_GT:    r.obj = (a > b) ? OBJ_T : OBJ_NIL;
            OP_LE:    r.obj = (a <= b) ? OBJ_T : OBJ_NIL;
            default:  r.obj = (a >= b) ? OBJ_T : OBJ_NIL;
          endcase
        end
      end
    endcase
    if (is_value) begin
      if (v < 0 || v > NUM_MAX) begin
        r.st = ST_RANGE;
      end else begin
        r.obj = word_t'(v + NUM_BIAS);
      end
    end
    return r;
  endfunction

  // Mostly zero, some short, a few long.
  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Numbers dominate, small ones so that most products stay in range.
  function automatic word_t pick_object();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return word_t'(NUM_BIAS + $urandom_range(0, 160));
    if (r < 62) return word_t'(NUM_BIAS + $urandom_range(0, NUM_MAX));
    if (r < 68) return word_t'(NUM_BIAS + NUM_MAX - $urandom_range(0, 2));
    if (r < 76) return word_t'($urandom_range(0, ATOM_END - 1));
    if (r < 84) return word_t'($urandom_range(ATOM_END, LIST_LAST + 1));
    if (r < 88) return word_t'($urandom_range(LIST_LAST + 2, NUM_BIAS - 1));
    if (r < 92) return word_t'($urandom_range(NUM_BIAS + NUM_MAX + 1, 32767));
    return word_t'($urandom_range(0, 32767));
  endfunction

  // Offer one transaction, hold it until taken, then record its answer.
  task automatic issue_op(op_t op, word_t x, word_t y, result_t answer);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'b0, y, x, op};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_results.push_back(answer);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // Result sink: ready stretches broken by stalls.
  initial begin
    int stall;
    while (!rst_n) @(posedge clk);
    forever begin
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk);
      stall = pick_gap();
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: result_object %0d status %0d",
               out_tdata[14:0], out_tdata[16:15]);
        fail_count++;
      end else begin
        oldest_result = pending_results.pop_front();
        if (out_tdata[14:0] !== oldest_result.obj) begin
          $error("result_object: expected %0d, got %0d", oldest_result.obj,
                 out_tdata[14:0]);
          fail_count++;
        end
        if (out_tdata[16:15] !== oldest_result.st) begin
          $error("status: expected %0d, got %0d", oldest_result.st,
                 out_tdata[16:15]);
          fail_count++;
        end
      end
    end
  end

  initial begin
    op_t     op;
    word_t   x;
    word_t   y;
    result_t answer;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (alu_rows[i]) begin
      if (alu_rows[i].typed) begin
        answer.obj = alu_rows[i].obj;
        answer.st  = alu_rows[i].st;
      end else begin
        answer = lisp_alu_answer(alu_rows[i].op, alu_rows[i].x, alu_rows[i].y);
      end
      issue_op(alu_rows[i].op, alu_rows[i].x, alu_rows[i].y, answer);
    end
    drain_results();

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == 200) drain_results();
      calm = (n >= 300 && n < 360);
      op = op_t'($urandom_range(0, 15));
      x  = pick_object();
      y  = pick_object();
      if (op == OP_EQ && $urandom_range(0, 3) == 0) y = x;
      if ((op == OP_QUOT || op == OP_REM) && $urandom_range(0, 9) == 0) begin
        y = word_t'(NUM_BIAS);
      end
      issue_op(op, x, y, lisp_alu_answer(op, x, y));
    end

    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_count == 0) begin
      $display("tagged_object_alu regression: pass");
    end else begin
      $display("tagged_object_alu regression: fail");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("tagged_object_alu regression: fail");
    $finish;
  end

endmodule

// File: tagged_object_alu.f
sv/tobj_pkg.sv
sv/tagged_object_alu.sv
dv/tb_tagged_object_alu.sv
